FILE: rtl/siv_pkg.sv
package siv_pkg;

    localparam int VEL_FRAC    = 8;
    localparam int TAB_FRAC    = 20;
    localparam int NORM_TOP    = 40;
    localparam int NORM_STAGES = 6;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic       valid;
        logic [1:0] wheel;
        logic       zero;
        logic       sat;
    } t_tag;

    // arctangent of 2^-i in units of 2^-20 rad
    function automatic longint atan_entry(input int i);
        longint r;
        case (i)
            0:       r = 823550;
            1:       r = 486170;
            2:       r = 256879;
            3:       r = 130396;
            4:       r = 65451;
            5:       r = 32757;
            6:       r = 16383;
            default: r = (i <= TAB_FRAC) ? (longint'(1) << (TAB_FRAC - i)) : longint'(0);
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/siv_stream_if.sv
interface siv_in_if #(
    parameter int VEL_WIDTH   = 16,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VEL_WIDTH-1:0]   vel_x;
    logic signed [VEL_WIDTH-1:0]   vel_y;
    logic signed [VEL_WIDTH-1:0]   yaw_rate;
    logic signed [ANGLE_WIDTH-1:0] measured_angle0;
    logic signed [ANGLE_WIDTH-1:0] measured_angle1;
    logic signed [ANGLE_WIDTH-1:0] measured_angle2;
    logic signed [ANGLE_WIDTH-1:0] measured_angle3;

    modport source (
        output valid, vel_x, vel_y, yaw_rate,
        output measured_angle0, measured_angle1, measured_angle2, measured_angle3,
        input  ready
    );
    modport sink (
        input  valid, vel_x, vel_y, yaw_rate,
        input  measured_angle0, measured_angle1, measured_angle2, measured_angle3,
        output ready
    );
endinterface

interface siv_out_if #(
    parameter int VEL_WIDTH   = 16,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] target_angle0;
    logic signed [ANGLE_WIDTH-1:0] target_angle1;
    logic signed [ANGLE_WIDTH-1:0] target_angle2;
    logic signed [ANGLE_WIDTH-1:0] target_angle3;
    logic signed [VEL_WIDTH-1:0]   target_speed0;
    logic signed [VEL_WIDTH-1:0]   target_speed1;
    logic signed [VEL_WIDTH-1:0]   target_speed2;
    logic signed [VEL_WIDTH-1:0]   target_speed3;

    modport source (
        output valid,
        output target_angle0, target_angle1, target_angle2, target_angle3,
        output target_speed0, target_speed1, target_speed2, target_speed3,
        input  ready
    );
    modport sink (
        input  valid,
        input  target_angle0, target_angle1, target_angle2, target_angle3,
        input  target_speed0, target_speed1, target_speed2, target_speed3,
        output ready
    );
endinterface

FILE: rtl/swerve_inverse_kinematics_unit.sv
// Four-wheel swerve inverse kinematics. A request carries the chassis velocity set and the
// four measured steering angles; the block returns steering targets and drive speeds for
// all four wheels. The wheels share one pipeline and enter it one per cycle while the
// pipeline is not stopped, and a new request is taken as the last wheel of the previous one
// enters. Each wheel passes a 4-stage front end (rotation-term multiply, corner sum, squares,
// radicand), VEL_WIDTH square-root cells, 6 normalizing shift cells, CORDIC_STEPS vectoring
// cells and 3 angle-finishing stages. The output register holds a finished result while the
// next request is already in flight; the pipeline only stops when a further result is ready
// and the output is still not taken.
module swerve_inverse_kinematics_unit #(
    parameter int VEL_WIDTH    = 16,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    siv_in_if.sink      i_in,
    siv_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import siv_pkg::*;

    localparam int VW = VEL_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int CS = CORDIC_STEPS;
    localparam int XW = 2 * VW - 6;
    localparam int NW = (XW > 43) ? XW : 43;
    localparam int CW = 45;
    localparam int ZW = 25;
    localparam int NS = NORM_STAGES;

    localparam logic [2:0] REG_OFFSET0     = 3'd0;
    localparam logic [2:0] REG_OFFSET1     = 3'd1;
    localparam logic [2:0] REG_OFFSET2     = 3'd2;
    localparam logic [2:0] REG_OFFSET3     = 3'd3;
    localparam logic [2:0] REG_HALF_LENGTH = 3'd4;
    localparam logic [2:0] REG_HALF_WIDTH  = 3'd5;

    localparam logic [31:0] HL_RST = 32'd5120;
    localparam logic [31:0] HW_RST = 32'd4480;
    localparam logic [VW-1:0] CAP = VW'((64'd1 << (VW - 1)) - 64'd1);
    localparam logic signed [ZW-1:0] PI20 = ZW'(4 * atan_entry(0));

    // configuration
    logic signed [AW-1:0] r_offset [4];
    logic [VW-1:0]        r_half_length, r_half_width;
    logic                 cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset[0]   <= '0;
            r_offset[1]   <= '0;
            r_offset[2]   <= '0;
            r_offset[3]   <= '0;
            r_half_length <= HL_RST[VW-1:0];
            r_half_width  <= HW_RST[VW-1:0];
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_OFFSET0:     r_offset[0]   <= pwdata[AW-1:0];
                REG_OFFSET1:     r_offset[1]   <= pwdata[AW-1:0];
                REG_OFFSET2:     r_offset[2]   <= pwdata[AW-1:0];
                REG_OFFSET3:     r_offset[3]   <= pwdata[AW-1:0];
                REG_HALF_LENGTH: r_half_length <= pwdata[VW-1:0];
                REG_HALF_WIDTH:  r_half_width  <= pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_OFFSET0:     prdata = 32'({r_offset[0]});
            REG_OFFSET1:     prdata = 32'({r_offset[1]});
            REG_OFFSET2:     prdata = 32'({r_offset[2]});
            REG_OFFSET3:     prdata = 32'({r_offset[3]});
            REG_HALF_LENGTH: prdata = 32'(r_half_length);
            REG_HALF_WIDTH:  prdata = 32'(r_half_width);
            default:         prdata = '0;
        endcase
    end

    // request holding and wheel sequencer
    logic                 en, in_ready, in_take;
    logic                 r_busy;
    logic [1:0]           r_cnt;
    logic signed [VW-1:0] r_vx, r_vy, r_wz;
    logic signed [AW-1:0] r_meas [4];

    t_tag                 post_tag;
    logic signed [AW-1:0] post_angle;
    logic signed [VW-1:0] post_speed;
    logic                 post_last;
    logic                 r_out_valid;

    assign post_last = post_tag.valid && (post_tag.wheel == 2'd3);
    assign en        = !(post_last && r_out_valid && !o_out.ready);
    assign in_ready  = en && (!r_busy || (r_cnt == 2'd3));
    assign in_take   = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (en) begin
            if (in_take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_vx      <= i_in.vel_x;
            r_vy      <= i_in.vel_y;
            r_wz      <= i_in.yaw_rate;
            r_meas[0] <= i_in.measured_angle0;
            r_meas[1] <= i_in.measured_angle1;
            r_meas[2] <= i_in.measured_angle2;
            r_meas[3] <= i_in.measured_angle3;
        end
    end

    // front end
    t_tag                 sq_tag  [VW+1];
    logic signed [XW-1:0] sq_x    [VW+1];
    logic signed [XW-1:0] sq_y    [VW+1];
    logic [XW-1:0]        sq_m    [VW+1];
    logic signed [AW-1:0] sq_meas [VW+1];
    logic [2*VW-1:0]      sq_rad  [VW+1];
    logic [VW+2:0]        sq_rem  [VW+1];
    logic [VW-1:0]        sq_root [VW+1];

    siv_front #(.VW(VW), .AW(AW), .XW(XW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_issue       (r_busy),
        .i_wheel       (r_cnt),
        .i_vel_x       (r_vx),
        .i_vel_y       (r_vy),
        .i_yaw_rate    (r_wz),
        .i_half_length (r_half_length),
        .i_half_width  (r_half_width),
        .i_meas        (r_meas[r_cnt]),
        .o_tag         (sq_tag[0]),
        .o_x           (sq_x[0]),
        .o_y           (sq_y[0]),
        .o_m           (sq_m[0]),
        .o_rad         (sq_rad[0]),
        .o_meas        (sq_meas[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < VW; g++) begin : g_sqrt
        siv_sqrt_cell #(.VW(VW), .AW(AW), .XW(XW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (sq_tag[g]),
            .i_x     (sq_x[g]),
            .i_y     (sq_y[g]),
            .i_m     (sq_m[g]),
            .i_meas  (sq_meas[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .o_tag   (sq_tag[g+1]),
            .o_x     (sq_x[g+1]),
            .o_y     (sq_y[g+1]),
            .o_m     (sq_m[g+1]),
            .o_meas  (sq_meas[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1])
        );
    end

    // normalizing shift
    t_tag                 nm_tag  [NS+1];
    logic signed [NW-1:0] nm_x    [NS+1];
    logic signed [NW-1:0] nm_y    [NS+1];
    logic [NW-1:0]        nm_m    [NS+1];
    logic signed [AW-1:0] nm_meas [NS+1];
    logic [VW-1:0]        nm_spd  [NS+1];

    assign nm_tag[0]  = sq_tag[VW];
    assign nm_x[0]    = NW'(sq_x[VW]);
    assign nm_y[0]    = NW'(sq_y[VW]);
    assign nm_m[0]    = NW'(sq_m[VW]);
    assign nm_meas[0] = sq_meas[VW];
    assign nm_spd[0]  = (sq_tag[VW].sat || (sq_root[VW] > CAP)) ? CAP : sq_root[VW];

    for (genvar g = 0; g < NS; g++) begin : g_norm
        siv_norm_cell #(.K(NS - 1 - g), .VW(VW), .AW(AW), .NW(NW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (nm_tag[g]),
            .i_x     (nm_x[g]),
            .i_y     (nm_y[g]),
            .i_m     (nm_m[g]),
            .i_meas  (nm_meas[g]),
            .i_spd   (nm_spd[g]),
            .o_tag   (nm_tag[g+1]),
            .o_x     (nm_x[g+1]),
            .o_y     (nm_y[g+1]),
            .o_m     (nm_m[g+1]),
            .o_meas  (nm_meas[g+1]),
            .o_spd   (nm_spd[g+1])
        );
    end

    // cordic vectoring, left half plane turned by pi first
    t_tag                 cd_tag  [CS+1];
    logic signed [CW-1:0] cd_x    [CS+1];
    logic signed [CW-1:0] cd_y    [CS+1];
    logic signed [ZW-1:0] cd_z    [CS+1];
    logic signed [AW-1:0] cd_meas [CS+1];
    logic [VW-1:0]        cd_spd  [CS+1];
    logic signed [CW-1:0] xc, yc;

    // normalized components fit well inside the cordic width
    assign xc = CW'(nm_x[NS]);
    assign yc = CW'(nm_y[NS]);

    always_comb begin
        if (xc[CW-1]) begin
            cd_x[0] = -xc;
            cd_y[0] = -yc;
            cd_z[0] = yc[CW-1] ? -PI20 : PI20;
        end else begin
            cd_x[0] = xc;
            cd_y[0] = yc;
            cd_z[0] = '0;
        end
    end

    assign cd_tag[0]  = nm_tag[NS];
    assign cd_meas[0] = nm_meas[NS];
    assign cd_spd[0]  = nm_spd[NS];

    for (genvar g = 0; g < CS; g++) begin : g_cordic
        siv_cordic_cell #(.IDX(g), .VW(VW), .AW(AW), .CW(CW), .ZW(ZW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (cd_tag[g]),
            .i_x     (cd_x[g]),
            .i_y     (cd_y[g]),
            .i_z     (cd_z[g]),
            .i_meas  (cd_meas[g]),
            .i_spd   (cd_spd[g]),
            .o_tag   (cd_tag[g+1]),
            .o_x     (cd_x[g+1]),
            .o_y     (cd_y[g+1]),
            .o_z     (cd_z[g+1]),
            .o_meas  (cd_meas[g+1]),
            .o_spd   (cd_spd[g+1])
        );
    end

    siv_post #(.VW(VW), .AW(AW), .ZW(ZW)) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tag    (cd_tag[CS]),
        .i_z      (cd_z[CS]),
        .i_meas   (cd_meas[CS]),
        .i_spd    (cd_spd[CS]),
        .i_offset (r_offset),
        .o_tag    (post_tag),
        .o_angle  (post_angle),
        .o_speed  (post_speed)
    );

    // gather the four wheels of a request into the output register
    logic signed [AW-1:0] r_col_ang [3];
    logic signed [VW-1:0] r_col_spd [3];
    logic signed [AW-1:0] r_out_ang [4];
    logic signed [VW-1:0] r_out_spd [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && post_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && post_tag.valid) begin
            if (post_tag.wheel == 2'd3) begin
                r_out_ang[0] <= r_col_ang[0];
                r_out_ang[1] <= r_col_ang[1];
                r_out_ang[2] <= r_col_ang[2];
                r_out_ang[3] <= post_angle;
                r_out_spd[0] <= r_col_spd[0];
                r_out_spd[1] <= r_col_spd[1];
                r_out_spd[2] <= r_col_spd[2];
                r_out_spd[3] <= post_speed;
            end else begin
                r_col_ang[post_tag.wheel] <= post_angle;
                r_col_spd[post_tag.wheel] <= post_speed;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.target_angle0 = r_out_ang[0];
    assign o_out.target_angle1 = r_out_ang[1];
    assign o_out.target_angle2 = r_out_ang[2];
    assign o_out.target_angle3 = r_out_ang[3];
    assign o_out.target_speed0 = r_out_spd[0];
    assign o_out.target_speed1 = r_out_spd[1];
    assign o_out.target_speed2 = r_out_spd[2];
    assign o_out.target_speed3 = r_out_spd[3];

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == 2'd0))
        else $error("wheel counter moved while no request is held");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_busy && (r_cnt != 2'd3)) |=> (r_busy && (r_cnt == $past(r_cnt) + 2'd1)))
        else $error("wheel sequence skipped or stopped");

    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && post_last) |=> r_out_valid)
        else $error("last wheel did not reach the output register");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (post_last && r_out_valid && !o_out.ready) |-> !in_ready)
        else $error("request taken while pipeline is stopped");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_spd[3] != {1'b1, {(VW-1){1'b0}}}))
        else $error("drive speed outside saturated range");

endmodule

FILE: rtl/siv_front.sv
module siv_front #(
    parameter int VW = 16,
    parameter int AW = 16,
    parameter int XW = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_issue,
    input  logic [1:0]           i_wheel,
    input  logic signed [VW-1:0] i_vel_x,
    input  logic signed [VW-1:0] i_vel_y,
    input  logic signed [VW-1:0] i_yaw_rate,
    input  logic [VW-1:0]        i_half_length,
    input  logic [VW-1:0]        i_half_width,
    input  logic signed [AW-1:0] i_meas,
    output siv_pkg::t_tag        o_tag,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic [XW-1:0]        o_m,
    output logic [2*VW-1:0]      o_rad,
    output logic signed [AW-1:0] o_meas
);
    import siv_pkg::*;

    localparam int PW = 2 * VW + 1;
    localparam logic [XW-1:0] CAP = XW'((64'd1 << (VW - 1)) - 64'd1);
    localparam logic signed [PW-1:0] RND = PW'(1 << (VEL_FRAC - 1));

    t_tag                 r1_tag, r2_tag, r3_tag, r4_tag;
    logic signed [PW-1:0] r1_pw, r1_pl;
    logic signed [VW-1:0] r1_vx, r1_vy;
    logic signed [AW-1:0] r1_meas, r2_meas, r3_meas, r4_meas;
    logic signed [XW-1:0] r2_x, r2_y, r3_x, r3_y, r4_x, r4_y;
    logic [XW-1:0]        r3_m, r4_m;
    logic [2*VW-3:0]      r3_sqx, r3_sqy;
    logic [2*VW-1:0]      r4_rad;

    t_tag                 n1_tag, n3_tag;
    logic signed [PW-1:0] n1_pw, n1_pl;
    logic signed [PW-1:0] tw_full, tl_full;
    logic signed [XW-1:0] tw, tl, n2_x, n2_y;
    logic [XW-1:0]        ax, ay;

    always_comb begin
        n1_tag       = '0;
        n1_tag.valid = i_issue;
        n1_tag.wheel = i_wheel;
        n1_pw = PW'(i_yaw_rate) * $signed({{(VW+1){1'b0}}, i_half_width});
        n1_pl = PW'(i_yaw_rate) * $signed({{(VW+1){1'b0}}, i_half_length});
    end

    // rotation terms rounded to the velocity format, then corner signs
    always_comb begin
        tw_full = (r1_pw + RND) >>> VEL_FRAC;
        tl_full = (r1_pl + RND) >>> VEL_FRAC;
        tw = tw_full[XW-1:0];
        tl = tl_full[XW-1:0];
        if (r1_tag.wheel == 2'd0 || r1_tag.wheel == 2'd3) begin
            n2_x = XW'(r1_vx) - tw;
        end else begin
            n2_x = XW'(r1_vx) + tw;
        end
        if (r1_tag.wheel == 2'd0 || r1_tag.wheel == 2'd1) begin
            n2_y = XW'(r1_vy) + tl;
        end else begin
            n2_y = XW'(r1_vy) - tl;
        end
    end

    always_comb begin
        ax = r2_x[XW-1] ? XW'(-r2_x) : XW'(r2_x);
        ay = r2_y[XW-1] ? XW'(-r2_y) : XW'(r2_y);
        n3_tag      = r2_tag;
        n3_tag.sat  = (ax > CAP) || (ay > CAP);
        n3_tag.zero = (r2_x == '0) && (r2_y == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r4_tag <= '0;
        end else if (i_en) begin
            r1_tag <= n1_tag;
            r2_tag <= r1_tag;
            r3_tag <= n3_tag;
            r4_tag <= r3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pw   <= n1_pw;
            r1_pl   <= n1_pl;
            r1_vx   <= i_vel_x;
            r1_vy   <= i_vel_y;
            r1_meas <= i_meas;
            r2_x    <= n2_x;
            r2_y    <= n2_y;
            r2_meas <= r1_meas;
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_m    <= (ax > ay) ? ax : ay;
            r3_sqx  <= ax[VW-2:0] * ax[VW-2:0];
            r3_sqy  <= ay[VW-2:0] * ay[VW-2:0];
            r3_meas <= r2_meas;
            r4_x    <= r3_x;
            r4_y    <= r3_y;
            r4_m    <= r3_m;
            r4_rad  <= (2*VW)'(r3_sqx) + (2*VW)'(r3_sqy);
            r4_meas <= r3_meas;
        end
    end

    assign o_tag  = r4_tag;
    assign o_x    = r4_x;
    assign o_y    = r4_y;
    assign o_m    = r4_m;
    assign o_rad  = r4_rad;
    assign o_meas = r4_meas;

endmodule

FILE: rtl/siv_sqrt_cell.sv
module siv_sqrt_cell #(
    parameter int VW = 16,
    parameter int AW = 16,
    parameter int XW = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  siv_pkg::t_tag        i_tag,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic [XW-1:0]        i_m,
    input  logic signed [AW-1:0] i_meas,
    input  logic [2*VW-1:0]      i_rad,
    input  logic [VW+2:0]        i_rem,
    input  logic [VW-1:0]        i_root,
    output siv_pkg::t_tag        o_tag,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic [XW-1:0]        o_m,
    output logic signed [AW-1:0] o_meas,
    output logic [2*VW-1:0]      o_rad,
    output logic [VW+2:0]        o_rem,
    output logic [VW-1:0]        o_root
);
    import siv_pkg::*;

    localparam int RW = VW + 3;

    logic [RW-1:0] rem_sh, trial, n_rem;
    logic [VW-1:0] n_root;

    // one root bit per cell, two radicand bits shifted in
    always_comb begin
        rem_sh = {i_rem[RW-3:0], i_rad[2*VW-1 -: 2]};
        trial  = {1'b0, i_root, 2'b01};
        if (rem_sh >= trial) begin
            n_rem  = rem_sh - trial;
            n_root = {i_root[VW-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh;
            n_root = {i_root[VW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else if (i_en) begin
            o_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= i_x;
            o_y    <= i_y;
            o_m    <= i_m;
            o_meas <= i_meas;
            o_rad  <= {i_rad[2*VW-3:0], 2'b00};
            o_rem  <= n_rem;
            o_root <= n_root;
        end
    end

endmodule

FILE: rtl/siv_norm_cell.sv
module siv_norm_cell #(
    parameter int K  = 0,
    parameter int VW = 16,
    parameter int AW = 16,
    parameter int NW = 43
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  siv_pkg::t_tag        i_tag,
    input  logic signed [NW-1:0] i_x,
    input  logic signed [NW-1:0] i_y,
    input  logic [NW-1:0]        i_m,
    input  logic signed [AW-1:0] i_meas,
    input  logic [VW-1:0]        i_spd,
    output siv_pkg::t_tag        o_tag,
    output logic signed [NW-1:0] o_x,
    output logic signed [NW-1:0] o_y,
    output logic [NW-1:0]        o_m,
    output logic signed [AW-1:0] o_meas,
    output logic [VW-1:0]        o_spd
);
    import siv_pkg::*;

    localparam int S = 1 << K;

    logic                 go_left, go_right;
    logic signed [NW-1:0] n_x, n_y;
    logic [NW-1:0]        n_m;

    // one binary step of the shift that puts the larger component in [2^40, 2^41)
    always_comb begin
        go_left  = (i_m >> (NORM_TOP + 1 - S)) == '0;
        go_right = (i_m >> (NORM_TOP + S)) != '0;
        if (go_left) begin
            n_x = i_x <<< S;
            n_y = i_y <<< S;
            n_m = i_m << S;
        end else if (go_right) begin
            n_x = i_x >>> S;
            n_y = i_y >>> S;
            n_m = i_m >> S;
        end else begin
            n_x = i_x;
            n_y = i_y;
            n_m = i_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else if (i_en) begin
            o_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_m    <= n_m;
            o_meas <= i_meas;
            o_spd  <= i_spd;
        end
    end

endmodule

FILE: rtl/siv_cordic_cell.sv
module siv_cordic_cell #(
    parameter int IDX = 0,
    parameter int VW  = 16,
    parameter int AW  = 16,
    parameter int CW  = 45,
    parameter int ZW  = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  siv_pkg::t_tag        i_tag,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic signed [AW-1:0] i_meas,
    input  logic [VW-1:0]        i_spd,
    output siv_pkg::t_tag        o_tag,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic signed [AW-1:0] o_meas,
    output logic [VW-1:0]        o_spd
);
    import siv_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(IDX));

    logic signed [CW-1:0] xs, ys, n_x, n_y;
    logic signed [ZW-1:0] n_z;

    always_comb begin
        xs = i_x >>> IDX;
        ys = i_y >>> IDX;
        if (!i_y[CW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else if (i_en) begin
            o_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_meas <= i_meas;
            o_spd  <= i_spd;
        end
    end

endmodule

FILE: rtl/siv_post.sv
module siv_post #(
    parameter int VW = 16,
    parameter int AW = 16,
    parameter int ZW = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  siv_pkg::t_tag        i_tag,
    input  logic signed [ZW-1:0] i_z,
    input  logic signed [AW-1:0] i_meas,
    input  logic [VW-1:0]        i_spd,
    input  logic signed [AW-1:0] i_offset [4],
    output siv_pkg::t_tag        o_tag,
    output logic signed [AW-1:0] o_angle,
    output logic signed [VW-1:0] o_speed
);
    import siv_pkg::*;

    localparam int AF = AW - 3;
    localparam int EW = AW + 3;
    localparam int RS = (AF < TAB_FRAC) ? TAB_FRAC - AF : 0;
    localparam int LS = (AF < TAB_FRAC) ? 0 : AF - TAB_FRAC;
    localparam longint RND = (longint'(1) << RS) >> 1;
    localparam longint unsigned PI_V = (PI_Q30 + (64'd1 << (29 - AF))) >> (30 - AF);
    localparam longint unsigned HP_V = (PI_Q30 + (64'd1 << (30 - AF))) >> (31 - AF);
    localparam logic signed [EW-1:0] P  = EW'(PI_V);
    localparam logic signed [EW-1:0] P2 = EW'(2 * PI_V);
    localparam logic signed [EW-1:0] HP = EW'(HP_V);

    function automatic logic signed [EW-1:0] f_wrap(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] r;
        if (v > P) begin
            r = v - P2;
        end else if (v < -P) begin
            r = v + P2;
        end else begin
            r = v;
        end
        return r;
    endfunction

    t_tag                 r1_tag, r2_tag;
    logic signed [EW-1:0] r1_ang, r2_ang, r2_d;
    logic signed [AW-1:0] r1_meas;
    logic [VW-1:0]        r1_spd, r2_spd;

    logic signed [63:0]   zl, zr;
    logic signed [EW-1:0] a0, n1_ang, n3_ang;
    logic signed [VW-1:0] n3_spd;

    always_comb begin
        zl = 64'(i_z);
        zr = ((zl + RND) >>> RS) <<< LS;
        a0 = i_tag.zero ? '0 : zr[EW-1:0];
        n1_ang = f_wrap(a0 - EW'(i_offset[i_tag.wheel]));
    end

    // turn by pi toward the measured angle when the error exceeds pi/2
    always_comb begin
        if (r2_d > HP) begin
            n3_ang = f_wrap(r2_ang - P);
            n3_spd = -$signed(r2_spd);
        end else if (r2_d < -HP) begin
            n3_ang = f_wrap(r2_ang + P);
            n3_spd = -$signed(r2_spd);
        end else begin
            n3_ang = r2_ang;
            n3_spd = $signed(r2_spd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            o_tag  <= '0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            o_tag  <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ang  <= n1_ang;
            r1_meas <= i_meas;
            r1_spd  <= i_spd;
            r2_ang  <= r1_ang;
            r2_d    <= f_wrap(r1_ang - EW'(r1_meas));
            r2_spd  <= r1_spd;
            o_angle <= n3_ang[AW-1:0];
            o_speed <= n3_spd;
        end
    end

endmodule
